### rtl/tfs_pkg.sv
package tfs_pkg;

  localparam int unsigned PixelBitsDefault = 16;
  localparam int unsigned FifoDepthDefault = 2;

  localparam logic [7:0] WidthReset  = 8'd160;
  localparam logic [7:0] HeightReset = 8'd120;

  localparam logic [7:0] Sync0     = 8'hAA;
  localparam logic [7:0] Sync1     = 8'h55;
  localparam logic [7:0] FrameType = 8'h01;
  localparam logic [7:0] ZeroByte  = 8'h00;

  localparam logic [7:0] RegWidth  = 8'd0;
  localparam logic [7:0] RegHeight = 8'd1;

  localparam int unsigned StepW = 5;
  localparam logic [StepW-1:0] StepSync0   = 5'd0;
  localparam logic [StepW-1:0] StepSync1   = 5'd1;
  localparam logic [StepW-1:0] StepType    = 5'd2;
  localparam logic [StepW-1:0] StepNumHi   = 5'd3;
  localparam logic [StepW-1:0] StepNumLo   = 5'd4;
  localparam logic [StepW-1:0] StepWidthHi = 5'd5;
  localparam logic [StepW-1:0] StepWidthLo = 5'd6;
  localparam logic [StepW-1:0] StepHghtHi  = 5'd7;
  localparam logic [StepW-1:0] StepHghtLo  = 5'd8;
  localparam logic [StepW-1:0] StepLen3    = 5'd9;
  localparam logic [StepW-1:0] StepLen2    = 5'd10;
  localparam logic [StepW-1:0] StepLen1    = 5'd11;
  localparam logic [StepW-1:0] StepLen0    = 5'd12;
  localparam logic [StepW-1:0] StepPixHi   = 5'd13;
  localparam logic [StepW-1:0] StepPixLo   = 5'd14;
  localparam logic [StepW-1:0] StepSumHi   = 5'd15;
  localparam logic [StepW-1:0] StepSumLo   = 5'd16;

  typedef struct packed {
    logic        frame_start;
    logic        frame_end;
    logic [15:0] frame_num;
    logic [7:0]  width;
    logic [7:0]  height;
    logic [16:0] payload_len;
  } cmd_t;

endpackage

### rtl/tfs_if.sv
interface tfs_pixel_if;
  logic        valid;
  logic        ready;
  logic [15:0] pixel_value;
  modport source (output valid, output pixel_value, input ready);
  modport sink (input valid, input pixel_value, output ready);
endinterface

interface tfs_byte_if;
  logic       valid;
  logic       ready;
  logic [7:0] out_byte;
  logic       run_last;
  logic       frame_last;
  modport source (output valid, output out_byte, output run_last, output frame_last,
                  input ready);
  modport sink (input valid, input out_byte, input run_last, input frame_last,
                output ready);
endinterface

interface tfs_cfg_if;
  logic       valid;
  logic       ready;
  logic [7:0] index;
  logic [7:0] data;
  modport source (output valid, output index, output data, input ready);
  modport sink (input valid, input index, input data, output ready);
endinterface

### rtl/thermal_frame_serializer_top.sv
// Channel   Dir  Handshake     Payload
// cfg_i     in   valid/ready   index (0 width, 1 height), data
// pixel_i   in   valid/ready   pixel_value
// byte_o    out  valid/ready   out_byte, run_last, frame_last
//
// The output register sends one byte per cycle while byte_o.ready holds, so a pixel inside a frame takes 2 bytes,
// the first pixel of a frame 15 and the last one 4 (17 for a one-pixel frame).
// The front classifies each pixel in its cycle of acceptance and queues a command in a queue of
// FifoDepth entries; it stalls only when that queue is full.
// Reset is asynchronous and needs no clearing pass; sizes return to 160 by 120.
// A stalled output beat holds its register while the queue keeps filling.
module thermal_frame_serializer_top
  import tfs_pkg::*;
#(
  parameter int unsigned PixelBits = PixelBitsDefault,
  parameter int unsigned FifoDepth = FifoDepthDefault
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  tfs_cfg_if.sink     cfg_i,
  tfs_pixel_if.sink   pixel_i,
  tfs_byte_if.source  byte_o
);

  localparam int unsigned EntryW = $bits(cmd_t) + PixelBits;

  cmd_t                 push_cmd, pop_cmd;
  logic [PixelBits-1:0] push_pixel, pop_pixel;
  logic                 push, full, pop, empty;
  logic [EntryW-1:0]    pop_data;

  tfs_front #(.PixelBits(PixelBits)) u_front (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .cfg_i   (cfg_i),
    .pixel_i (pixel_i),
    .push_o  (push),
    .full_i  (full),
    .cmd_o   (push_cmd),
    .pixel_o (push_pixel)
  );

  tfs_fifo #(.Width(EntryW), .Depth(FifoDepth)) u_fifo (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (push),
    .push_data_i ({push_cmd, push_pixel}),
    .full_o      (full),
    .pop_i       (pop),
    .pop_data_o  (pop_data),
    .empty_o     (empty)
  );

  assign pop_cmd   = cmd_t'(pop_data[EntryW-1:PixelBits]);
  assign pop_pixel = pop_data[PixelBits-1:0];

  tfs_back #(.PixelBits(PixelBits)) u_back (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .empty_i (empty),
    .cmd_i   (pop_cmd),
    .pixel_i (pop_pixel),
    .pop_o   (pop),
    .byte_o  (byte_o)
  );

  a_accept_pushes : assert property (@(posedge clk_i) disable iff (!rst_ni)
    pixel_i.valid && pixel_i.ready |-> push && !full)
    else $error("Accepted pixel did not enter the command queue.");

  a_pop_ends_run : assert property (@(posedge clk_i) disable iff (!rst_ni)
    pop |=> byte_o.valid && byte_o.run_last)
    else $error("Retired command did not leave a closing beat.");

  a_frame_last_closes_run : assert property (@(posedge clk_i) disable iff (!rst_ni)
    byte_o.valid && byte_o.frame_last |-> byte_o.run_last)
    else $error("Checksum beat is not the closing beat of its pixel.");

  a_pop_needs_entry : assert property (@(posedge clk_i) disable iff (!rst_ni)
    pop |-> !empty)
    else $error("Back end retired a command from an empty queue.");

endmodule

### rtl/tfs_fifo.sv
module tfs_fifo #(
  parameter int unsigned Width = 8,
  parameter int unsigned Depth = 2
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             push_i,
  input  logic [Width-1:0] push_data_i,
  output logic             full_o,
  input  logic             pop_i,
  output logic [Width-1:0] pop_data_o,
  output logic             empty_o
);

  localparam int unsigned PtrW = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int unsigned CntW = $clog2(Depth + 1);
  localparam logic [PtrW-1:0] LastPtr = PtrW'(Depth - 1);
  localparam logic [CntW-1:0] FullCnt = CntW'(Depth);

  logic [Width-1:0] mem_q [Depth];
  logic [PtrW-1:0]  wr_ptr_q, wr_ptr_d, rd_ptr_q, rd_ptr_d;
  logic [CntW-1:0]  count_q, count_d;
  logic             do_push, do_pop;

  assign full_o     = (count_q == FullCnt);
  assign empty_o    = (count_q == '0);
  assign do_push    = push_i && !full_o;
  assign do_pop     = pop_i && !empty_o;
  assign pop_data_o = mem_q[rd_ptr_q];

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    count_d  = count_q;
    if (do_push) begin
      wr_ptr_d = (wr_ptr_q == LastPtr) ? '0 : wr_ptr_q + 1'b1;
    end
    if (do_pop) begin
      rd_ptr_d = (rd_ptr_q == LastPtr) ? '0 : rd_ptr_q + 1'b1;
    end
    if (do_push && !do_pop) begin
      count_d = count_q + 1'b1;
    end else if (do_pop && !do_push) begin
      count_d = count_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_ptr_q] <= push_data_i;
    end
  end

endmodule

### rtl/tfs_front.sv
module tfs_front
  import tfs_pkg::*;
#(
  parameter int unsigned PixelBits = PixelBitsDefault
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  tfs_cfg_if.sink              cfg_i,
  tfs_pixel_if.sink            pixel_i,
  output logic                 push_o,
  input  logic                 full_i,
  output cmd_t                 cmd_o,
  output logic [PixelBits-1:0] pixel_o
);

  logic [7:0]  width_q, height_q;
  logic [15:0] pix_idx_q, pix_idx_d;
  logic [15:0] frame_num_q, frame_num_d;
  logic [15:0] frame_px;
  logic [16:0] next_idx;
  logic        frame_end;
  logic        accept;

  assign cfg_i.ready   = 1'b1;
  assign pixel_i.ready = !full_i;
  assign accept        = pixel_i.valid && !full_i;
  assign push_o        = pixel_i.valid;

  // A frame size of zero, or a count that has overrun a shrunken size, ends the frame.
  assign frame_px  = {8'd0, width_q} * {8'd0, height_q};
  assign next_idx  = {1'b0, pix_idx_q} + 17'd1;
  assign frame_end = (next_idx >= {1'b0, frame_px});

  always_comb begin
    cmd_o.frame_start = (pix_idx_q == '0);
    cmd_o.frame_end   = frame_end;
    cmd_o.frame_num   = frame_num_q;
    cmd_o.width       = width_q;
    cmd_o.height      = height_q;
    cmd_o.payload_len = {frame_px, 1'b0};
    pixel_o           = pixel_i.pixel_value[PixelBits-1:0];
  end

  always_comb begin
    pix_idx_d   = pix_idx_q;
    frame_num_d = frame_num_q;
    if (accept) begin
      if (frame_end) begin
        pix_idx_d   = '0;
        frame_num_d = frame_num_q + 16'd1;
      end else begin
        pix_idx_d = next_idx[15:0];
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      width_q     <= WidthReset;
      height_q    <= HeightReset;
      pix_idx_q   <= '0;
      frame_num_q <= '0;
    end else begin
      pix_idx_q   <= pix_idx_d;
      frame_num_q <= frame_num_d;
      if (cfg_i.valid) begin
        if (cfg_i.index == RegWidth) begin
          width_q <= cfg_i.data;
        end else if (cfg_i.index == RegHeight) begin
          height_q <= cfg_i.data;
        end
      end
    end
  end

endmodule

### rtl/tfs_back.sv
module tfs_back
  import tfs_pkg::*;
#(
  parameter int unsigned PixelBits = PixelBitsDefault
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 empty_i,
  input  cmd_t                 cmd_i,
  input  logic [PixelBits-1:0] pixel_i,
  output logic                 pop_o,
  tfs_byte_if.source           byte_o
);

  logic [StepW-1:0] step_q, step_d, cur_step;
  logic [15:0]      sum_q, sum_d;
  logic [15:0]      pix16;
  logic [7:0]       byte_d, byte_q;
  logic             run_last_d, run_last_q, frame_last_d, frame_last_q;
  logic             valid_q, load, last_step;

  assign pix16    = 16'(pixel_i);
  assign load     = !empty_i && (!valid_q || byte_o.ready);
  assign cur_step = (step_q == StepSync0 && !cmd_i.frame_start) ? StepPixHi : step_q;
  assign last_step = cmd_i.frame_end ? (cur_step == StepSumLo) : (cur_step == StepPixLo);
  assign pop_o    = load && last_step;

  always_comb begin
    unique case (cur_step)
      StepSync0:   byte_d = Sync0;
      StepSync1:   byte_d = Sync1;
      StepType:    byte_d = FrameType;
      StepNumHi:   byte_d = cmd_i.frame_num[15:8];
      StepNumLo:   byte_d = cmd_i.frame_num[7:0];
      StepWidthHi: byte_d = ZeroByte;
      StepWidthLo: byte_d = cmd_i.width;
      StepHghtHi:  byte_d = ZeroByte;
      StepHghtLo:  byte_d = cmd_i.height;
      StepLen3:    byte_d = ZeroByte;
      StepLen2:    byte_d = {7'd0, cmd_i.payload_len[16]};
      StepLen1:    byte_d = cmd_i.payload_len[15:8];
      StepLen0:    byte_d = cmd_i.payload_len[7:0];
      StepPixHi:   byte_d = pix16[15:8];
      StepPixLo:   byte_d = pix16[7:0];
      StepSumHi:   byte_d = sum_q[15:8];
      StepSumLo:   byte_d = sum_q[7:0];
      default:     byte_d = ZeroByte;
    endcase
  end

  always_comb begin
    run_last_d   = last_step;
    frame_last_d = (cur_step == StepSumLo);
    step_d       = step_q;
    sum_d        = sum_q;
    if (load) begin
      step_d = last_step ? StepSync0 : cur_step + 1'b1;
      if (cur_step == StepSync0) begin
        sum_d = {8'd0, byte_d};
      end else if (cur_step < StepSumHi) begin
        sum_d = sum_q + {8'd0, byte_d};
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      step_q  <= StepSync0;
      sum_q   <= '0;
      valid_q <= 1'b0;
    end else begin
      step_q <= step_d;
      sum_q  <= sum_d;
      if (load) begin
        valid_q <= 1'b1;
      end else if (byte_o.ready) begin
        valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (load) begin
      byte_q       <= byte_d;
      run_last_q   <= run_last_d;
      frame_last_q <= frame_last_d;
    end
  end

  assign byte_o.valid      = valid_q;
  assign byte_o.out_byte   = byte_q;
  assign byte_o.run_last   = run_last_q;
  assign byte_o.frame_last = frame_last_q;

endmodule
